// File: sv/top_k_sorted_insert_table_top_defines.svh
// Assertion macros for the top-k table.
// Each expects clk_i and rst_ni in scope.
`ifndef TOP_K_SORTED_INSERT_TABLE_TOP_DEFINES_SVH
`define TOP_K_SORTED_INSERT_TABLE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TKST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TKST_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TKST_ASSERT(lbl, prop, msg)
`define TKST_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: sv/tkst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tkst_pkg;

  localparam int unsigned EntriesDef = 10;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned ScoreW     = 32;
  localparam int unsigned ByteW      = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [ByteW-1:0]  first;
    logic [ByteW-1:0]  second;
    logic [ByteW-1:0]  third;
    logic [ByteW-1:0]  level;
  } rec_t;

  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    rec_t             wr_data;
  } mem_req_t;

  function automatic rec_t boot_rec(input logic [SlotW-1:0] slot);
    rec_t r;
    r = '0;
    case (slot)
      4'd0: r = '{score: 32'd500000, first: "Y", second: "A", third: "K", level: 8'd15};
      4'd1: r = '{score: 32'd450000, first: "E", second: "W", third: "E", level: 8'd14};
      4'd2: r = '{score: 32'd400000, first: "C", second: "O", third: "W", level: 8'd13};
      4'd3: r = '{score: 32'd350000, first: "G", second: "N", third: "U", level: 8'd12};
      4'd4: r = '{score: 32'd300000, first: "O", second: "X", third: " ", level: 8'd11};
      4'd5: r = '{score: 32'd250000, first: "E", second: "L", third: "K", level: 8'd10};
      4'd6: r = '{score: 32'd200000, first: "D", second: "O", third: "E", level: 8'd9};
      4'd7: r = '{score: 32'd150000, first: "M", second: "O", third: "O", level: 8'd8};
      4'd8: r = '{score: 32'd100000, first: "B", second: "A", third: "A", level: 8'd7};
      4'd9: r = '{score: 32'd50000,  first: "F", second: "U", third: "R", level: 8'd6};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/tkst_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module tkst_mem #(
  parameter int unsigned ENTRIES = tkst_pkg::EntriesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tkst_pkg::mem_req_t req_i,
  output tkst_pkg::rec_t          rd_data_o
);
  import tkst_pkg::*;

  localparam int unsigned IdxW = $clog2(ENTRIES);

  rec_t             mem_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  rec_t             raw_q;
  logic             rvalid_q;
  logic [IdxW-1:0]  raddr_q;

  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;

  assign waddr = req_i.wr_addr[IdxW-1:0];
  assign raddr = req_i.rd_addr[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[waddr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      raw_q   <= mem_q[raddr];
      raddr_q <= raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[waddr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[raddr];
      end
    end
  end

  // untouched slots still hold the boot table
  assign rd_data_o = rvalid_q ? raw_q : boot_rec(SlotW'(raddr_q));

endmodule
`default_nettype wire

// File: sv/tkst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "top_k_sorted_insert_table_top_defines.svh"
module tkst_ctrl #(
  parameter int unsigned ENTRIES = tkst_pkg::EntriesDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     op_i,
  input  wire tkst_pkg::rec_t           rec_i,
  input  wire logic [tkst_pkg::SlotW-1:0] index_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          out_qual_o,
  output logic [tkst_pkg::SlotW-1:0]    out_rank_o,
  output tkst_pkg::rec_t                out_rec_o,
  output tkst_pkg::mem_req_t            mem_req_o,
  input  wire tkst_pkg::rec_t           rd_data_i
);
  import tkst_pkg::*;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(ENTRIES - 1);
  localparam logic [SlotW:0]   EntCnt   = (SlotW+1)'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_SHIFT,
    S_PLACE,
    S_OUT
  } state_e;

  state_e           state_q;
  logic             op_q;
  rec_t             new_q;
  logic             range_q;
  logic [SlotW-1:0] ptr_q;
  logic             res_qual_q;
  logic [SlotW-1:0] res_rank_q;
  rec_t             res_rec_q;
  logic             out_valid_q;
  logic             out_qual_q;
  logic [SlotW-1:0] out_rank_q;
  rec_t             out_rec_q;

  logic accept;
  logic in_range;
  logic rd_less;
  logic out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, index_i} < EntCnt;
  assign rd_less    = rd_data_i.score < new_q.score;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    mem_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i == OP_READ) begin
            mem_req_o.rd_en   = in_range;
            mem_req_o.rd_addr = index_i;
          end else begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = LastSlot;
          end
        end
      end
      S_CHECK: begin
        if (rd_less) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = ptr_q - SlotW'(1);
        end
      end
      S_SHIFT: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = ptr_q;
        if (rd_less) begin
          mem_req_o.wr_data = rd_data_i;
          if (ptr_q != SlotW'(1)) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = ptr_q - SlotW'(2);
          end
        end else begin
          mem_req_o.wr_data = new_q;
        end
      end
      S_PLACE: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = ptr_q;
        mem_req_o.wr_data = new_q;
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= 1'b0;
      new_q       <= '0;
      range_q     <= 1'b0;
      ptr_q       <= '0;
      res_qual_q  <= 1'b0;
      res_rank_q  <= '0;
      res_rec_q   <= '0;
      out_valid_q <= 1'b0;
      out_qual_q  <= 1'b0;
      out_rank_q  <= '0;
      out_rec_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= op_i;
            new_q   <= rec_i;
            range_q <= in_range;
            ptr_q   <= LastSlot;
            state_q <= (op_i == OP_READ) ? S_READ : S_CHECK;
          end
        end
        S_READ: begin
          res_qual_q <= 1'b0;
          res_rank_q <= '0;
          res_rec_q  <= range_q ? rd_data_i : '0;
          state_q    <= S_OUT;
        end
        S_CHECK: begin
          if (rd_less) begin
            state_q <= S_SHIFT;
          end else begin
            res_qual_q <= 1'b0;
            res_rank_q <= '0;
            res_rec_q  <= '0;
            state_q    <= S_OUT;
          end
        end
        S_SHIFT: begin
          if (rd_less) begin
            ptr_q <= ptr_q - SlotW'(1);
            if (ptr_q == SlotW'(1)) begin
              state_q <= S_PLACE;
            end
          end else begin
            res_qual_q <= 1'b1;
            res_rank_q <= ptr_q;
            res_rec_q  <= '0;
            state_q    <= S_OUT;
          end
        end
        S_PLACE: begin
          res_qual_q <= 1'b1;
          res_rank_q <= ptr_q;
          res_rec_q  <= '0;
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_qual_q  <= res_qual_q;
            out_rank_q  <= res_rank_q;
            out_rec_q   <= res_rec_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_qual_o  = out_qual_q;
  assign out_rank_o  = out_rank_q;
  assign out_rec_o   = out_rec_q;

  `TKST_ASSERT_NEVER(a_rw_same_slot, mem_req_o.wr_en && mem_req_o.rd_en && (mem_req_o.wr_addr == mem_req_o.rd_addr), "read and write hit the same slot")
  `TKST_ASSERT(a_shift_ptr, (state_q == S_SHIFT) |-> (ptr_q != '0) && (ptr_q <= LastSlot), "shift pointer out of range")
  `TKST_ASSERT(a_rank_range, (out_valid_q && out_qual_q) |-> ({1'b0, out_rank_q} < EntCnt), "rank beyond table")
  `TKST_ASSERT(a_read_unqual, (state_q == S_READ) |=> !res_qual_q && (res_rank_q == '0), "read result carries a rank")
  `TKST_ASSERT(a_insert_quiet, (state_q == S_OUT && !op_q) |-> (res_rec_q == '0), "insert result carries entry data")

endmodule
`default_nettype wire

// File: sv/top_k_sorted_insert_table_top.sv
// Top-k table: ENTRIES records kept in descending score order.
// Input channel (in_valid_i / in_ready_o) takes one request: operation 0
// inserts the record (score, three initials, level), operation 1 reads
// the slot at index_i. Output channel (out_valid_o / out_ready_i) returns
// one result per request: qualified and rank for an insert, the entry
// fields for a read (zeros for an index at or beyond ENTRIES).
// A read passes through states S_READ and S_OUT; an insert through
// S_CHECK, then, if it qualifies, S_SHIFT once per slot it walks (and
// S_PLACE for slot 0), then S_OUT. A request occupies the block throughout;
// the next is taken the cycle after the result is loaded into the
// output register. The table memory, with one read and one write port, is
// walked one slot per cycle from the bottom up, moving each lower record
// down one slot.
// Reset loads the boot table at once through per-slot valid bits; no
// clearing pass is needed. A stalled receiver holds the result in the
// output register; a new request is still taken meanwhile and its
// result waits in the block until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module top_k_sorted_insert_table_top #(
  parameter int unsigned ENTRIES = tkst_pkg::EntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [31:0] score_i,
  input  wire logic [7:0]  first_initial_i,
  input  wire logic [7:0]  second_initial_i,
  input  wire logic [7:0]  third_initial_i,
  input  wire logic [7:0]  level_i,
  input  wire logic [3:0]  index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             qualified_o,
  output logic [3:0]       rank_o,
  output logic [31:0]      entry_score_o,
  output logic [7:0]       entry_first_initial_o,
  output logic [7:0]       entry_second_initial_o,
  output logic [7:0]       entry_third_initial_o,
  output logic [7:0]       entry_level_o
);
  import tkst_pkg::*;

  rec_t     in_rec;
  rec_t     out_rec;
  rec_t     rd_data;
  mem_req_t mem_req;

  assign in_rec = '{score: score_i, first: first_initial_i, second: second_initial_i,
                    third: third_initial_i, level: level_i};

  tkst_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (operation_i),
    .rec_i      (in_rec),
    .index_i    (index_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_qual_o (qualified_o),
    .out_rank_o (rank_o),
    .out_rec_o  (out_rec),
    .mem_req_o  (mem_req),
    .rd_data_i  (rd_data)
  );

  tkst_mem #(
    .ENTRIES(ENTRIES)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  assign entry_score_o          = out_rec.score;
  assign entry_first_initial_o  = out_rec.first;
  assign entry_second_initial_o = out_rec.second;
  assign entry_third_initial_o  = out_rec.third;
  assign entry_level_o          = out_rec.level;

endmodule
`default_nettype wire

// File: dv/top_k_sorted_insert_table_top_tb.sv
`timescale 1ns / 1ps
module top_k_sorted_insert_table_top_tb;
  import tkst_pkg::*;

  localparam int unsigned ENTRIES    = tkst_pkg::EntriesDef;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned BatchLen   = 16;

  typedef struct packed {
    op_e        op;
    rec_t       rec;
    logic [3:0] index;
  } request_t;

  typedef struct packed {
    logic       qualified;
    logic [3:0] rank;
    rec_t       entry;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [31:0] score = '0;
  logic [7:0]  first_initial = '0;
  logic [7:0]  second_initial = '0;
  logic [7:0]  third_initial = '0;
  logic [7:0]  level = '0;
  logic [3:0]  index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        qualified;
  logic [3:0]  rank;
  logic [31:0] entry_score;
  logic [7:0]  entry_first_initial;
  logic [7:0]  entry_second_initial;
  logic [7:0]  entry_third_initial;
  logic [7:0]  entry_level;

  rec_t     board [ENTRIES];
  request_t pending_requests [$];
  result_t  awaited_results [$];
  request_t cur_req;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_inserts = 0;
  int unsigned n_qualified = 0;
  int unsigned n_reads = 0;
  int unsigned n_far_reads = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  top_k_sorted_insert_table_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .operation_i           (operation),
    .score_i               (score),
    .first_initial_i       (first_initial),
    .second_initial_i      (second_initial),
    .third_initial_i       (third_initial),
    .level_i               (level),
    .index_i               (index),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .qualified_o           (qualified),
    .rank_o                (rank),
    .entry_score_o         (entry_score),
    .entry_first_initial_o (entry_first_initial),
    .entry_second_initial_o(entry_second_initial),
    .entry_third_initial_o (entry_third_initial),
    .entry_level_o         (entry_level)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Insert shifts lower records down and drops the last; ties land below.
  function automatic result_t apply_to_board(request_t req);
    result_t res;
    int      pos;
    res = '0;
    pos = ENTRIES - 1;
    if (req.op == OP_INSERT) begin
      if (req.rec.score > board[ENTRIES-1].score) begin
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (board[i].score < req.rec.score) pos = i;
        end
        for (int i = ENTRIES - 1; i > pos; i--) board[i] = board[i-1];
        board[pos]    = req.rec;
        res.qualified = 1'b1;
        res.rank      = pos[3:0];
      end
    end else if (req.index < ENTRIES) begin
      res.entry = board[req.index];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    result_t want;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want = apply_to_board(cur_req);
        awaited_results.push_back(want);
        n_accepted++;
        if (cur_req.op == OP_INSERT) begin
          n_inserts++;
          if (want.qualified) n_qualified++;
        end else begin
          n_reads++;
          if (cur_req.index >= ENTRIES) n_far_reads++;
        end
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_requests.pop_front();
          in_valid       <= 1'b1;
          operation      <= cur_req.op;
          score          <= cur_req.rec.score;
          first_initial  <= cur_req.rec.first;
          second_initial <= cur_req.rec.second;
          third_initial  <= cur_req.rec.third;
          level          <= cur_req.rec.level;
          index          <= cur_req.index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = awaited_results.pop_front();
          n_results++;
          compare_field("qualified", 32'(want.qualified), 32'(qualified));
          compare_field("rank", 32'(want.rank), 32'(rank));
          compare_field("entry_score", want.entry.score, entry_score);
          compare_field("entry_first_initial", 32'(want.entry.first),
                        32'(entry_first_initial));
          compare_field("entry_second_initial", 32'(want.entry.second),
                        32'(entry_second_initial));
          compare_field("entry_third_initial", 32'(want.entry.third),
                        32'(entry_third_initial));
          compare_field("entry_level", 32'(want.entry.level), 32'(entry_level));
        end
      end
    end
  end

  task automatic queue_request(op_e op, logic [31:0] sc, logic [7:0] f, logic [7:0] s,
                               logic [7:0] t, logic [7:0] lv, logic [3:0] idx);
    request_t rq;
    rq.op         = op;
    rq.rec.score  = sc;
    rq.rec.first  = f;
    rq.rec.second = s;
    rq.rec.third  = t;
    rq.rec.level  = lv;
    rq.index      = idx;
    pending_requests.push_back(rq);
    n_queued++;
  endtask

  task automatic drain_requests();
    while (n_accepted != n_queued) @(posedge clk_i);
  endtask

  task automatic drain_results();
    drain_requests();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    string       tags;
    logic [31:0] sc;
    logic [3:0]  idx;
    int unsigned slot;
    op_e         op;
    tags = "YAKEWECOWGNUOX ELKDOEMOOBAAFUR";
    for (int i = 0; i < ENTRIES; i++) begin
      board[i] = '0;
      if (i < 10) begin
        board[i].score  = 32'd500000 - 32'd50000 * i;
        board[i].first  = tags[3*i];
        board[i].second = tags[3*i+1];
        board[i].third  = tags[3*i+2];
        board[i].level  = 8'(15 - i);
      end
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 47;
    queue_request(OP_READ, '0, '0, '0, '0, '0, 4'd0);
    queue_request(OP_READ, '1, '1, '1, '1, '1, 4'(ENTRIES - 1));
    queue_request(OP_READ, '0, '0, '0, '0, '0, 4'(ENTRIES));
    queue_request(OP_READ, '0, '0, '0, '0, '0, 4'd15);
    queue_request(OP_INSERT, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0);
    queue_request(OP_INSERT, 32'd50000, 8'h41, 8'h42, 8'h43, 8'd1, 4'd15);
    queue_request(OP_INSERT, 32'd50001, 8'hff, 8'hff, 8'hff, 8'hff, 4'd0);
    queue_request(OP_INSERT, 32'd500000, 8'h54, 8'h49, 8'h45, 8'd20, 4'd3);
    queue_request(OP_INSERT, 32'hffff_ffff, 8'h00, 8'hff, 8'h00, 8'h80, 4'd12);
    queue_request(OP_INSERT, 32'hffff_ffff, 8'hff, 8'h00, 8'hff, 8'h7f, 4'd5);
    queue_request(OP_INSERT, 32'd300000, 8'h5a, 8'h5a, 8'h5a, 8'd99, 4'd0);
    queue_request(OP_INSERT, 32'd100000, 8'h51, 8'h52, 8'h53, 8'd2, 4'd0);
    queue_request(OP_INSERT, 32'h8000_0000, 8'h01, 8'h02, 8'h03, 8'd4, 4'd0);
    for (int i = 0; i < ENTRIES; i++) queue_request(OP_READ, $urandom, '0, '0, '0, '0, 4'(i));
    queue_request(OP_READ, '0, '0, '0, '0, '0, 4'd14);
    drain_results();

    // Three idle profiles: sender light / receiver heavy, swapped, none.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 14 : 0;
      for (int b = 0; b < 17; b++) begin
        for (int k = 0; k < BatchLen; k++) begin
          op   = ($urandom_range(99) < 60) ? OP_INSERT : OP_READ;
          slot = $urandom_range(ENTRIES - 1);
          case ($urandom_range(5))
            0:       sc = $urandom;
            1:       sc = board[slot].score;
            2:       sc = board[slot].score + $urandom_range(1, 3000);
            3:       sc = board[slot].score - $urandom_range(0, 3000);
            4:       sc = board[0].score + $urandom_range(0, 20000);
            default: sc = board[ENTRIES-1].score + $urandom_range(0, 1);
          endcase
          idx = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(ENTRIES - 1));
          queue_request(op, sc, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), idx);
        end
        // hold the sender until every result is back now and then
        if (b % 5 == 4) drain_results();
        else drain_requests();
      end
    end

    drain_results();
    repeat (30) @(posedge clk_i);
    $display("Covered %0d requests: %0d inserts (%0d entered the table), %0d reads",
             n_accepted, n_inserts, n_qualified, n_reads);
    $display("%0d reads past the last slot, %0d results checked, %0d mismatches",
             n_far_reads, n_results, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
